### sv/hht_pkg.sv
// ---------------------------------------------------------------------------
// hht_pkg: shared types and constants for the HTTP header tokenizer
// Holds the phase encodings, role and event codes, byte constants and the
// default limits used by the tokenizer.
// ---------------------------------------------------------------------------
package hht_pkg;

    // Default limits
    localparam int unsigned BODY_CAPTURE_DEF = 16;
    localparam int unsigned MAX_BUFFER_DEF   = 2048;
    localparam int unsigned MAX_HEADERS_DEF  = 32;

    // Counter widths, fixed by the limit ranges
    localparam int unsigned BYTE_CNT_W = 11;
    localparam int unsigned BODY_CNT_W = 5;
    localparam int unsigned HDR_CNT_W  = 6;

    // Byte values the parser looks for
    localparam logic [7:0] CHAR_LF       = 8'd10;
    localparam logic [7:0] CHAR_CR       = 8'd13;
    localparam logic [7:0] CHAR_SPACE    = 8'd32;
    localparam logic [7:0] CHAR_DQUOTE   = 8'd34;
    localparam logic [7:0] CHAR_DOT      = 8'd46;
    localparam logic [7:0] CHAR_COLON    = 8'd58;
    localparam logic [7:0] CHAR_H        = 8'd72;
    localparam logic [7:0] CHAR_P        = 8'd80;
    localparam logic [7:0] CHAR_T        = 8'd84;
    localparam logic [7:0] CHAR_BSLASH   = 8'd92;
    localparam logic [7:0] PRINT_LO      = 8'd32;
    localparam logic [7:0] PRINT_HI      = 8'd126;

    // Line-end tracking
    typedef enum logic [2:0] {
        CRLF_NONE,
        CRLF_CR,
        CRLF_CRLF,
        CRLF_CRLFCR,
        CRLF_END
    } crlf_t;

    // Where in the message the parser is
    typedef enum logic [1:0] {
        SEC_START,
        SEC_HEADER,
        SEC_BODY
    } section_t;

    // Progress through the start line tokens
    typedef enum logic [2:0] {
        SF_NONE,
        SF_TOK1,
        SF_AFTER1,
        SF_TOK2,
        SF_AFTER2,
        SF_TOK3
    } start_phase_t;

    // Progress through one header line
    typedef enum logic [1:0] {
        HF_NAME,
        HF_COLON,
        HF_VALUE
    } hdr_phase_t;

    // Match of the H, T.., P letters in token 1
    typedef enum logic [1:0] {
        HM_NONE,
        HM_H,
        HM_T,
        HM_MATCH
    } http_match_t;

    typedef enum logic [1:0] {
        LK_UNKNOWN,
        LK_REQUEST,
        LK_STATUS
    } line_kind_t;

    typedef enum logic [2:0] {
        ROLE_NONE,
        ROLE_TOK1,
        ROLE_TOK2,
        ROLE_TOK3,
        ROLE_NAME,
        ROLE_VALUE,
        ROLE_BODY
    } byte_role_t;

    typedef enum logic [2:0] {
        EV_NONE,
        EV_LINE,
        EV_HDR_END,
        EV_MALFORMED,
        EV_BODY_DONE
    } parse_event_t;

    // Replace non-printable and quoting bytes with a dot
    function automatic logic [7:0] printable(input logic [7:0] b);
        logic bad;
        bad = (b < PRINT_LO) || (b > PRINT_HI) || (b == CHAR_DQUOTE) || (b == CHAR_BSLASH);
        return bad ? CHAR_DOT : b;
    endfunction

endpackage

### sv/http_header_tokenizer_unit.sv
// ---------------------------------------------------------------------------
// http_header_tokenizer_unit: streaming HTTP/1.1 header tokenizer
// Tags each payload byte with its role in the start line, header lines or
// body, cleans header bytes to printable text and reports line ends, end of
// headers, malformed input and the end of body capture.
// ---------------------------------------------------------------------------
//
// Channel   Dir  tdata                          tuser                     tlast
// s_        in   [7:0] payload_byte             [0] first_byte            last_byte
// m_        out  [7:0] clean_byte,              [2:0] byte_role,          result_last
//                [10:8] parse_event             [3] token_begin,
//                                               [5:4] line_kind
// cfg_      in   cfg_wdata = capture_enable (written when cfg_we is high)
//
// One transaction in gives one transaction out. Each byte is parsed in the
// cycle it is accepted and its result is registered, so a byte can be
// accepted every cycle while the result side does not stall. Input is taken
// whenever the output register is empty or being drained in the same cycle.
// Reset (aresetn low, synchronous) clears the parse state, empties the output
// register and sets capture_enable to one.
//
module http_header_tokenizer_unit
    import hht_pkg::*;
#(
    parameter int unsigned BODY_CAPTURE = BODY_CAPTURE_DEF,
    parameter int unsigned MAX_BUFFER   = MAX_BUFFER_DEF,
    parameter int unsigned MAX_HEADERS  = MAX_HEADERS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_we,
    input  logic        cfg_wdata,     // capture_enable
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] payload_byte
    input  logic        s_tuser,       // [0] first_byte
    input  logic        s_tlast,       // last_byte
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,       // [7:0] clean_byte, [10:8] parse_event
    output logic [5:0]  m_tuser,       // [2:0] byte_role, [3] token_begin, [5:4] line_kind
    output logic        m_tlast        // result_last
);

    localparam logic [11:0]          HdrCap   = 12'(MAX_BUFFER - BODY_CAPTURE);
    localparam logic [BODY_CNT_W-1:0] BodyCap = BODY_CNT_W'(BODY_CAPTURE);
    localparam logic [HDR_CNT_W-1:0]  MaxHdr  = HDR_CNT_W'(MAX_HEADERS);
    localparam logic [HDR_CNT_W-1:0]  HdrSat  = {HDR_CNT_W{1'b1}};

    // Parse state
    logic                  cap_en_reg;
    crlf_t                 crlf_reg,    crlf_next;
    section_t              section_reg, section_next;
    start_phase_t          sfp_reg,     sfp_next;
    hdr_phase_t            hfp_reg,     hfp_next;
    http_match_t           http_reg,    http_next;
    line_kind_t            kind_reg,    kind_next;
    logic [BYTE_CNT_W-1:0] byte_cnt_reg, byte_cnt_next;
    logic [BODY_CNT_W-1:0] body_cnt_reg, body_cnt_next;
    logic [HDR_CNT_W-1:0]  hdr_cnt_reg,  hdr_cnt_next;
    logic                  stopped_reg,  stopped_next;

    // Result register
    logic                  out_valid_reg;
    logic [7:0]            clean_reg,  clean_next;
    byte_role_t            role_reg,   role_next;
    logic                  tb_reg,     tb_next;
    line_kind_t            okind_reg,  okind_next;
    parse_event_t          event_reg,  event_next;
    logic                  last_reg;

    logic                  accept;
    logic                  name_start;
    logic                  line_ok;
    logic [7:0]            b;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign b        = s_tdata;

    // Parse one byte: next state and result fields
    always_comb begin
        crlf_next     = crlf_reg;
        section_next  = section_reg;
        sfp_next      = sfp_reg;
        hfp_next      = hfp_reg;
        http_next     = http_reg;
        kind_next     = kind_reg;
        byte_cnt_next = byte_cnt_reg;
        body_cnt_next = body_cnt_reg;
        hdr_cnt_next  = hdr_cnt_reg;
        stopped_next  = stopped_reg;
        clean_next    = 8'd0;
        role_next     = ROLE_NONE;
        tb_next       = 1'b0;
        okind_next    = LK_UNKNOWN;
        event_next    = EV_NONE;
        name_start    = 1'b0;
        line_ok       = 1'b0;

        if (cap_en_reg) begin
            // a first byte restarts the message
            if (s_tuser) begin
                crlf_next     = CRLF_NONE;
                section_next  = SEC_START;
                sfp_next      = SF_NONE;
                hfp_next      = HF_NAME;
                http_next     = HM_NONE;
                kind_next     = LK_UNKNOWN;
                byte_cnt_next = '0;
                body_cnt_next = '0;
                hdr_cnt_next  = '0;
                stopped_next  = 1'b0;
            end

            if (!stopped_next) begin
                if (section_next == SEC_BODY) begin
                    // pass body bytes through raw
                    clean_next    = b;
                    role_next     = ROLE_BODY;
                    tb_next       = (body_cnt_next == '0);
                    body_cnt_next = body_cnt_next + 1'b1;
                    if (body_cnt_next >= BodyCap) begin
                        event_next   = EV_BODY_DONE;
                        stopped_next = 1'b1;
                    end
                end else begin
                    clean_next = printable(b);
                    priority if (b == CHAR_CR) begin
                        if (crlf_next == CRLF_NONE)      crlf_next = CRLF_CR;
                        else if (crlf_next == CRLF_CRLF) crlf_next = CRLF_CRLFCR;
                    end else if (b == CHAR_LF) begin
                        if (crlf_next == CRLF_CR)          crlf_next = CRLF_CRLF;
                        else if (crlf_next == CRLF_CRLFCR) crlf_next = CRLF_END;
                    end else if (b == CHAR_SPACE && section_next == SEC_START) begin
                        // space separates start line tokens
                        if (sfp_next == SF_NONE || sfp_next == SF_TOK1) begin
                            sfp_next = SF_AFTER1;
                            if (kind_next == LK_UNKNOWN) kind_next = LK_REQUEST;
                        end else if (sfp_next == SF_TOK2) begin
                            sfp_next = SF_AFTER2;
                        end else if (sfp_next == SF_TOK3) begin
                            role_next = ROLE_TOK3;
                        end
                        crlf_next = CRLF_NONE;
                    end else if (b == CHAR_SPACE) begin
                        // space inside a header line; after CRLF it folds the line
                        if (crlf_next == CRLF_NONE) begin
                            if (hfp_next == HF_NAME)       role_next = ROLE_NAME;
                            else if (hfp_next == HF_VALUE) role_next = ROLE_VALUE;
                        end
                    end else if (b == CHAR_COLON && section_next == SEC_HEADER) begin
                        if (hfp_next == HF_NAME)       hfp_next  = HF_COLON;
                        else if (hfp_next == HF_VALUE) role_next = ROLE_VALUE;
                        crlf_next = CRLF_NONE;
                    end else begin
                        // a token byte; after CRLF it closes the previous line
                        if (crlf_next == CRLF_CRLF) begin
                            line_ok = (section_next == SEC_START) ? (sfp_next == SF_TOK3)
                                                                  : (hfp_next == HF_VALUE);
                            if (!line_ok) begin
                                event_next   = EV_MALFORMED;
                                stopped_next = 1'b1;
                            end else begin
                                event_next = EV_LINE;
                                if (section_next == SEC_HEADER) begin
                                    hdr_cnt_next = hdr_cnt_next + 1'b1;
                                    if (hdr_cnt_next >= MaxHdr) stopped_next = 1'b1;
                                end
                                if (!stopped_next) begin
                                    section_next = SEC_HEADER;
                                    hfp_next     = HF_NAME;
                                    name_start   = 1'b1;
                                end
                            end
                        end
                        if (!stopped_next) begin
                            if (section_next == SEC_START) begin
                                priority if (sfp_next == SF_NONE || sfp_next == SF_TOK1) begin
                                    role_next = ROLE_TOK1;
                                    tb_next   = (sfp_next == SF_NONE);
                                    sfp_next  = SF_TOK1;
                                    // look for H, T.., P in token 1
                                    if (http_next == HM_NONE && b == CHAR_H) begin
                                        http_next = HM_H;
                                    end else if ((http_next == HM_H || http_next == HM_T)
                                                 && b == CHAR_T) begin
                                        http_next = HM_T;
                                    end else if (http_next == HM_T && b == CHAR_P) begin
                                        http_next = HM_MATCH;
                                        kind_next = LK_STATUS;
                                    end
                                end else if (sfp_next == SF_AFTER1) begin
                                    role_next = ROLE_TOK2;
                                    tb_next   = 1'b1;
                                    sfp_next  = SF_TOK2;
                                end else if (sfp_next == SF_TOK2) begin
                                    role_next = ROLE_TOK2;
                                end else if (sfp_next == SF_AFTER2) begin
                                    role_next = ROLE_TOK3;
                                    tb_next   = 1'b1;
                                    sfp_next  = SF_TOK3;
                                end else begin
                                    role_next = ROLE_TOK3;
                                end
                            end else if (name_start || hfp_next == HF_NAME) begin
                                role_next = ROLE_NAME;
                                tb_next   = name_start;
                            end else if (hfp_next == HF_COLON) begin
                                role_next = ROLE_VALUE;
                                tb_next   = 1'b1;
                                hfp_next  = HF_VALUE;
                            end else begin
                                role_next = ROLE_VALUE;
                            end
                        end
                        crlf_next = CRLF_NONE;
                    end

                    // end of headers on the final LF
                    if (!stopped_next && crlf_next == CRLF_END) begin
                        event_next = EV_HDR_END;
                        if (section_next == SEC_HEADER && hfp_next == HF_VALUE
                            && hdr_cnt_next != HdrSat) begin
                            hdr_cnt_next = hdr_cnt_next + 1'b1;
                        end
                        section_next  = SEC_BODY;
                        crlf_next     = CRLF_NONE;
                        body_cnt_next = '0;
                        if (BODY_CAPTURE == 0) stopped_next = 1'b1;
                    end

                    // header length cap and running out of bytes
                    if (!stopped_next && section_next != SEC_BODY) begin
                        if ({1'b0, byte_cnt_next} + 12'd1 >= HdrCap) begin
                            event_next   = EV_MALFORMED;
                            stopped_next = 1'b1;
                        end else begin
                            byte_cnt_next = byte_cnt_next + 1'b1;
                        end
                        if (s_tlast && !stopped_next) event_next = EV_MALFORMED;
                    end
                end

                if (s_tlast) stopped_next = 1'b1;
                okind_next = kind_next;
            end
        end
    end

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_en_reg <= 1'b1;
        end else if (cfg_we) begin
            cap_en_reg <= cfg_wdata;
        end
    end

    // Parse state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crlf_reg      <= CRLF_NONE;
            section_reg   <= SEC_START;
            sfp_reg       <= SF_NONE;
            hfp_reg       <= HF_NAME;
            http_reg      <= HM_NONE;
            kind_reg      <= LK_UNKNOWN;
            byte_cnt_reg  <= '0;
            body_cnt_reg  <= '0;
            hdr_cnt_reg   <= '0;
            stopped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                crlf_reg      <= crlf_next;
                section_reg   <= section_next;
                sfp_reg       <= sfp_next;
                hfp_reg       <= hfp_next;
                http_reg      <= http_next;
                kind_reg      <= kind_next;
                byte_cnt_reg  <= byte_cnt_next;
                body_cnt_reg  <= body_cnt_next;
                hdr_cnt_reg   <= hdr_cnt_next;
                stopped_reg   <= stopped_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the result payload until the next transaction
    always_ff @(posedge aclk) begin
        if (accept) begin
            clean_reg <= clean_next;
            role_reg  <= role_next;
            tb_reg    <= tb_next;
            okind_reg <= okind_next;
            event_reg <= event_next;
            last_reg  <= cap_en_reg && s_tlast && !(stopped_reg && !s_tuser);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, event_reg, clean_reg};
    assign m_tuser  = {okind_reg, tb_reg, role_reg};
    assign m_tlast  = last_reg;

    // Checks
    a_last_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && cap_en_reg && s_tlast |=> stopped_reg)
        else $error("last byte did not stop parsing");

    a_disabled_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !cap_en_reg |=> m_tvalid && m_tdata == 16'd0 && m_tuser == 6'd0 && !m_tlast)
        else $error("ignored byte gave a nonzero result");

    a_body_no_crlf: assert property (@(posedge aclk) disable iff (!aresetn)
        section_reg == SEC_BODY |-> crlf_reg == CRLF_NONE)
        else $error("line-end tracking active in body");

    a_hdr_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        hdr_cnt_reg <= MaxHdr)
        else $error("header count passed its limit");

    a_byte_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, byte_cnt_reg} < HdrCap)
        else $error("header byte count passed the length cap");

endmodule

### bench/testbench.sv
// ---------------------------------------------------------------------------
// testbench: self-checking bench for http_header_tokenizer_unit
// Streams payload bytes through the tokenizer with random bursts and result
// stalls. A local parse model predicts every result from the accepted bytes
// and a checker compares each result transaction field by field. Covers
// request and status lines, header lines, body capture, malformed input, the
// header line limit, the header length cap and capture_enable on and off.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import hht_pkg::*;

    localparam int unsigned HDR_LIMIT    = MAX_BUFFER_DEF - BODY_CAPTURE_DEF;
    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned RANDOM_BYTES = 1750;
    localparam string       CRLF         = "\015\012";

    // One predicted result transaction
    typedef struct {
        logic [7:0]   clean;
        byte_role_t   role;
        logic         tb;
        line_kind_t   kind;
        parse_event_t ev;
        logic         last;
    } tok_result_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;  // [7:0] payload_byte
    logic        s_tuser   = 1'b0;   // [0] first_byte
    logic        s_tlast   = 1'b0;   // last_byte
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;            // [7:0] clean_byte, [10:8] parse_event
    logic [5:0]  m_tuser;            // [2:0] byte_role, [3] token_begin, [5:4] line_kind
    logic        m_tlast;            // result_last

    // Parse model state
    logic         cap_en;
    crlf_t        crlf_ph;
    section_t     sect;
    start_phase_t sf_ph;
    hdr_phase_t   hf_ph;
    http_match_t  hm_ph;
    line_kind_t   kind;
    logic [10:0]  hdr_bytes;
    logic [4:0]   body_seen;
    logic [5:0]   lines_done;
    logic         halted;
    logic         byte_ignored;

    tok_result_t  pending_results[$];
    tok_result_t  head;
    int unsigned  mismatch_count = 0;
    int unsigned  parsed_bytes   = 0;
    int unsigned  burst_left     = 0;
    int unsigned  cycle_count    = 0;

    http_header_tokenizer_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // Stall the result side: always ready, mostly ready, mostly stalled, toggling
    always @(posedge aclk) begin
        case (cycle_count[11:10])
            2'd0: m_tready <= 1'b1;
            2'd1: m_tready <= ($urandom_range(0, 3) != 0);
            2'd2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= cycle_count[2];
        endcase
    end

    // ------------------------------------------------------------------
    // Parse model
    // ------------------------------------------------------------------
    function automatic void clear_state();
        crlf_ph    = CRLF_NONE;
        sect       = SEC_START;
        sf_ph      = SF_NONE;
        hf_ph      = HF_NAME;
        hm_ph      = HM_NONE;
        kind       = LK_UNKNOWN;
        hdr_bytes  = '0;
        body_seen  = '0;
        lines_done = '0;
        halted     = 1'b0;
    endfunction

    function automatic tok_result_t tokenize_byte(logic [7:0] b, logic first, logic last);
        tok_result_t r;
        logic        name_start;
        logic        line_ok;
        r.clean      = 8'h00;
        r.role       = ROLE_NONE;
        r.tb         = 1'b0;
        r.kind       = LK_UNKNOWN;
        r.ev         = EV_NONE;
        r.last       = 1'b0;
        name_start   = 1'b0;
        byte_ignored = 1'b1;
        if (!cap_en) return r;
        if (first) clear_state();
        if (halted) return r;
        byte_ignored = 1'b0;

        if (sect == SEC_BODY) begin
            // Pass body bytes through raw until the capture count is reached
            r.clean   = b;
            r.role    = ROLE_BODY;
            r.tb      = (body_seen == 0);
            body_seen = body_seen + 1'b1;
            if (body_seen >= BODY_CAPTURE_DEF) begin
                r.ev   = EV_BODY_DONE;
                halted = 1'b1;
            end
        end else begin
            // Replace control, high, quote and backslash bytes with a dot
            if (b < 8'd32 || b > 8'd126 || b == CHAR_DQUOTE || b == CHAR_BSLASH)
                r.clean = CHAR_DOT;
            else
                r.clean = b;

            if (b == CHAR_CR) begin
                if (crlf_ph == CRLF_NONE) crlf_ph = CRLF_CR;
                else if (crlf_ph == CRLF_CRLF) crlf_ph = CRLF_CRLFCR;
            end else if (b == CHAR_LF) begin
                if (crlf_ph == CRLF_CR) crlf_ph = CRLF_CRLF;
                else if (crlf_ph == CRLF_CRLFCR) crlf_ph = CRLF_END;
            end else if (b == CHAR_SPACE && sect == SEC_START) begin
                if (sf_ph <= SF_TOK1) begin
                    sf_ph = SF_AFTER1;
                    if (kind == LK_UNKNOWN) kind = LK_REQUEST;
                end else if (sf_ph == SF_TOK2) begin
                    sf_ph = SF_AFTER2;
                end else if (sf_ph == SF_TOK3) begin
                    r.role = ROLE_TOK3;
                end
                crlf_ph = CRLF_NONE;
            end else if (b == CHAR_SPACE) begin
                // Space after CRLF continues the line and keeps the line end pending
                if (crlf_ph == CRLF_NONE) begin
                    if (hf_ph == HF_NAME) r.role = ROLE_NAME;
                    else if (hf_ph == HF_VALUE) r.role = ROLE_VALUE;
                end
            end else if (b == CHAR_COLON && sect == SEC_HEADER) begin
                if (hf_ph == HF_NAME) hf_ph = HF_COLON;
                else if (hf_ph == HF_VALUE) r.role = ROLE_VALUE;
                crlf_ph = CRLF_NONE;
            end else begin
                // First ordinary byte after CRLF closes the previous line
                if (crlf_ph == CRLF_CRLF) begin
                    line_ok = (sect == SEC_START) ? (sf_ph == SF_TOK3) : (hf_ph == HF_VALUE);
                    if (!line_ok) begin
                        r.ev   = EV_MALFORMED;
                        halted = 1'b1;
                    end else begin
                        r.ev = EV_LINE;
                        if (sect == SEC_HEADER) begin
                            lines_done = lines_done + 1'b1;
                            if (lines_done >= MAX_HEADERS_DEF) halted = 1'b1;
                        end
                        if (!halted) begin
                            sect       = SEC_HEADER;
                            hf_ph      = HF_NAME;
                            name_start = 1'b1;
                        end
                    end
                end
                if (!halted) begin
                    if (sect == SEC_START) begin
                        case (sf_ph)
                            SF_NONE, SF_TOK1: begin
                                r.role = ROLE_TOK1;
                                r.tb   = (sf_ph == SF_NONE);
                                sf_ph  = SF_TOK1;
                                if (hm_ph == HM_NONE && b == CHAR_H) begin
                                    hm_ph = HM_H;
                                end else if ((hm_ph == HM_H || hm_ph == HM_T) && b == CHAR_T) begin
                                    hm_ph = HM_T;
                                end else if (hm_ph == HM_T && b == CHAR_P) begin
                                    hm_ph = HM_MATCH;
                                    kind  = LK_STATUS;
                                end
                            end
                            SF_AFTER1: begin
                                r.role = ROLE_TOK2;
                                r.tb   = 1'b1;
                                sf_ph  = SF_TOK2;
                            end
                            SF_TOK2: r.role = ROLE_TOK2;
                            SF_AFTER2: begin
                                r.role = ROLE_TOK3;
                                r.tb   = 1'b1;
                                sf_ph  = SF_TOK3;
                            end
                            default: r.role = ROLE_TOK3;
                        endcase
                    end else if (name_start || hf_ph == HF_NAME) begin
                        r.role = ROLE_NAME;
                        r.tb   = name_start;
                    end else if (hf_ph == HF_COLON) begin
                        r.role = ROLE_VALUE;
                        r.tb   = 1'b1;
                        hf_ph  = HF_VALUE;
                    end else begin
                        r.role = ROLE_VALUE;
                    end
                end
                crlf_ph = CRLF_NONE;
            end

            // CRLFCRLF ends the headers and opens the body
            if (!halted && crlf_ph == CRLF_END) begin
                r.ev = EV_HDR_END;
                if (sect == SEC_HEADER && hf_ph == HF_VALUE && lines_done < 6'd63)
                    lines_done = lines_done + 1'b1;
                sect      = SEC_BODY;
                crlf_ph   = CRLF_NONE;
                body_seen = '0;
                if (BODY_CAPTURE_DEF == 0) halted = 1'b1;
            end
            // Apply the header length cap and the out-of-bytes check
            if (!halted && sect != SEC_BODY) begin
                if (int'(hdr_bytes) + 1 >= HDR_LIMIT) begin
                    r.ev   = EV_MALFORMED;
                    halted = 1'b1;
                end else begin
                    hdr_bytes = hdr_bytes + 1'b1;
                end
                if (last && !halted) r.ev = EV_MALFORMED;
            end
        end
        if (last) halted = 1'b1;
        r.kind = kind;
        r.last = last;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("MISMATCH at %0t ns: %s got 0x%0h expected 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result transaction with nothing pending, tdata", m_tdata, 0);
            end else begin
                head = pending_results.pop_front();
                if (m_tdata[7:0] !== head.clean)
                    report_mismatch("clean_byte", m_tdata[7:0], head.clean);
                if (m_tdata[10:8] !== head.ev)
                    report_mismatch("parse_event", m_tdata[10:8], head.ev);
                if (m_tdata[15:11] !== 5'd0)
                    report_mismatch("tdata padding", m_tdata[15:11], 0);
                if (m_tuser[2:0] !== head.role)
                    report_mismatch("byte_role", m_tuser[2:0], head.role);
                if (m_tuser[3] !== head.tb)
                    report_mismatch("token_begin", m_tuser[3], head.tb);
                if (m_tuser[5:4] !== head.kind)
                    report_mismatch("line_kind", m_tuser[5:4], head.kind);
                if (m_tlast !== head.last)
                    report_mismatch("result_last", m_tlast, head.last);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Send one byte in bursts with random gaps, then predict its result
    task automatic put_byte(logic [7:0] b, logic first, logic last);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 32);
        end
        burst_left--;
        s_tdata  <= b;
        s_tuser  <= first;
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(tokenize_byte(b, first, last));
        if (!byte_ignored) parsed_bytes++;
    endtask

    task automatic send_msg(input logic [7:0] msg[$], input logic first, input logic last);
        for (int i = 0; i < msg.size(); i++)
            put_byte(msg[i], first && i == 0, last && i == msg.size() - 1);
    endtask

    task automatic put_noise(int unsigned count);
        repeat (count)
            put_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                     $urandom_range(0, 7) == 0);
    endtask

    // Hold off new input until every pending result has drained
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic set_capture(logic en);
        drain_results();
        cfg_wdata <= en;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        cap_en     = en;
    endtask

    task automatic push_text(ref logic [7:0] msg[$], input string s);
        for (int i = 0; i < s.len(); i++) msg.push_back(s[i]);
    endtask

    // Printable token bytes, colon swapped out so names stay names
    task automatic push_word(ref logic [7:0] msg[$], input int unsigned len);
        logic [7:0] c;
        repeat (len) begin
            c = 8'($urandom_range(33, 126));
            msg.push_back((c == CHAR_COLON) ? 8'h2d : c);
        end
    endtask

    // Any byte but CR and LF
    task automatic push_value(ref logic [7:0] msg[$], input int unsigned len);
        logic [7:0] c;
        repeat (len) begin
            c = 8'($urandom_range(0, 255));
            msg.push_back((c == CHAR_CR || c == CHAR_LF) ? 8'h7e : c);
        end
    endtask

    // Well-formed header line: name_len + value_len + 3 bytes
    task automatic push_header(ref logic [7:0] msg[$], input int unsigned name_len,
                               input int unsigned value_len);
        push_word(msg, name_len);
        msg.push_back(CHAR_COLON);
        push_word(msg, 1);
        push_value(msg, value_len - 1);
        push_text(msg, CRLF);
    endtask

    task automatic send_text(string s, logic first, logic last);
        logic [7:0] msg[$];
        push_text(msg, s);
        send_msg(msg, first, last);
    endtask

    // Random message: start line, header lines, optional end, body, rare damage
    task automatic build_message(ref logic [7:0] msg[$]);
        int unsigned n;
        msg.delete();
        case ($urandom_range(0, 4))
            0: push_text(msg, "GET");
            1: push_text(msg, "HTTP/1.1");
            2: push_text(msg, "xHyTTzP");
            3: push_text(msg, "HTPP");
            default: push_word(msg, $urandom_range(1, 8));
        endcase
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) : 2;
        repeat (n) begin
            if ($urandom_range(0, 5) == 0) push_text(msg, "  ");
            else push_text(msg, " ");
            push_word(msg, $urandom_range(1, 10));
        end
        push_text(msg, CRLF);
        repeat ($urandom_range(0, 5)) begin
            push_word(msg, $urandom_range(1, 8));
            if ($urandom_range(0, 7) == 0) push_text(msg, " ");
            msg.push_back(CHAR_COLON);
            if ($urandom_range(0, 1) == 0) push_text(msg, " ");
            if ($urandom_range(0, 9) != 0) begin
                push_word(msg, 1);
                push_value(msg, $urandom_range(0, 12));
            end
            if ($urandom_range(0, 5) == 0) begin
                push_text(msg, {CRLF, " "});
                push_word(msg, $urandom_range(1, 4));
            end
            push_text(msg, CRLF);
        end
        if ($urandom_range(0, 7) != 0) push_text(msg, CRLF);
        repeat ($urandom_range(0, 24)) msg.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 7) == 0)
            msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom_range(0, 255));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed_cases();
        // status line, quote and backslash in a value, short body ending on last
        send_text({"HTP 200 OK", CRLF, "A: \"\\", CRLF, CRLF}, 1'b1, 1'b0);
        put_byte(8'h00, 1'b0, 1'b0);
        put_byte(8'hff, 1'b0, 1'b1);
        // bare start line accepted by CRLFCRLF, full body capture, then a dropped byte
        send_text({"x", CRLF, CRLF}, 1'b1, 1'b0);
        repeat (BODY_CAPTURE_DEF) put_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        put_byte("q", 1'b0, 1'b0);
        // start line without third token
        send_text({"a b", CRLF, "c"}, 1'b1, 1'b0);
        // header line without value
        send_text({"a b c", CRLF, "k:", CRLF, "z"}, 1'b1, 1'b0);
        // control and high bytes, continuation line, one body byte
        send_text({"a\001b c\200d", CRLF, " e", CRLF, CRLF, "\377"}, 1'b1, 1'b1);
        // payload runs out inside the start line
        send_text("GET", 1'b1, 1'b1);
    endtask

    task automatic test_capture_toggle();
        logic [7:0]  msg[$];
        int unsigned cut;
        build_message(msg);
        cut = $urandom_range(1, msg.size() - 1);
        set_capture(1'b1);
        for (int i = 0; i < cut; i++) put_byte(msg[i], i == 0, 1'b0);
        // parse state must survive the disabled stretch
        set_capture(1'b0);
        put_noise(12);
        set_capture(1'b1);
        for (int i = cut; i < msg.size(); i++) put_byte(msg[i], 1'b0, i == msg.size() - 1);
        set_capture(1'b0);
        put_noise(6);
        set_capture(1'b1);
    endtask

    task automatic test_header_limit();
        logic [7:0]  msg[$];
        int unsigned line_counts[4] = '{31, 32, 33, 40};
        foreach (line_counts[j]) begin
            msg.delete();
            push_text(msg, {"HTTP/1.0 200 OK", CRLF});
            repeat (line_counts[j]) push_header(msg, $urandom_range(1, 6), $urandom_range(1, 6));
            push_text(msg, CRLF);
            repeat (3) msg.push_back(8'($urandom_range(0, 255)));
            send_msg(msg, 1'b1, 1'b1);
        end
    endtask

    task automatic test_length_cap();
        logic [7:0] msg[$];
        // final LF lands exactly on the last header byte allowed
        push_text(msg, {"GET /big HTTP/1.1", CRLF});
        while (msg.size() < HDR_LIMIT - 200)
            push_header(msg, $urandom_range(1, 8), $urandom_range(60, 120));
        // closing CRLF takes two bytes, a one-byte name line adds four to its value
        push_header(msg, 1, HDR_LIMIT - msg.size() - 2 - 4);
        push_text(msg, CRLF);
        repeat (4) msg.push_back(8'($urandom_range(0, 255)));
        send_msg(msg, 1'b1, 1'b1);
        // headers never end, cap hit, trailing bytes dropped
        msg.delete();
        push_text(msg, {"HTTP/1.1 404 Gone", CRLF});
        while (msg.size() < HDR_LIMIT + 40)
            push_header(msg, $urandom_range(1, 8), $urandom_range(60, 120));
        send_msg(msg, 1'b1, 1'b0);
    endtask

    task automatic test_random_messages();
        logic [7:0] msg[$];
        parsed_bytes = 0;
        while (parsed_bytes < RANDOM_BYTES) begin
            if ($urandom_range(0, 9) == 0) begin
                put_noise($urandom_range(1, 30));
            end else begin
                build_message(msg);
                send_msg(msg, $urandom_range(0, 9) != 0, $urandom_range(0, 3) != 0);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Run control
    // ------------------------------------------------------------------
    initial begin
        cap_en = 1'b1;
        clear_state();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_cases();
        test_capture_toggle();
        test_header_limit();
        test_length_cap();
        test_random_messages();
        drain_results();
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
